[sv/tcg_pkg.sv]
// shared types and constants for the text console grid
`timescale 1ns / 1ps
package tcg_pkg;

  localparam int MODE_W = 2;
  localparam int CHAR_W = 8;
  localparam int RROW_W = 5;
  localparam int RCOL_W = 6;
  localparam int OCOL_W = 6;
  localparam int OROW_W = 5;

  typedef enum logic [1:0] {
    MODE_PUT   = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_READ  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  typedef enum logic [1:0] {
    KIND_CHAR,
    KIND_READ,
    KIND_OTHER
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP,
    ST_WRITE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic cap;
    logic apply;
    logic sweep_wr;
    logic put_wr;
    logic rd_issue;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  row_ok;
    logic  sweep_last;
    logic  out_free;
  } sts_t;

endpackage

[sv/tcg_if.sv]
// channel interfaces for input items and result items
`timescale 1ns / 1ps
interface tcg_in_if;
  logic                        valid;
  logic                        ready;
  logic [tcg_pkg::MODE_W-1:0]  mode;
  logic [tcg_pkg::CHAR_W-1:0]  char_code;
  logic [tcg_pkg::RROW_W-1:0]  read_row;
  logic [tcg_pkg::RCOL_W-1:0]  read_col;

  modport source (output valid, mode, char_code, read_row, read_col, input ready);
  modport sink   (input valid, mode, char_code, read_row, read_col, output ready);
endinterface

interface tcg_out_if;
  logic                        valid;
  logic                        ready;
  logic [tcg_pkg::OCOL_W-1:0]  cursor_col;
  logic [tcg_pkg::OROW_W-1:0]  cursor_row;
  logic [tcg_pkg::CHAR_W-1:0]  cell_char;
  logic                        scrolled;

  modport source (output valid, cursor_col, cursor_row, cell_char, scrolled, input ready);
  modport sink   (input valid, cursor_col, cursor_row, cell_char, scrolled, output ready);
endinterface

[sv/tcg_ctrl.sv]
// sequencing state machine for the text console grid
`timescale 1ns / 1ps
module tcg_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  tcg_pkg::sts_t sts,
  output tcg_pkg::cmd_t cmd
);

  tcg_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tcg_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      tcg_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = tcg_pkg::ST_EXEC;
        end
      end
      tcg_pkg::ST_EXEC: begin
        case (sts.kind)
          tcg_pkg::KIND_CHAR: begin
            // a row blanked by scroll or clear is filled with spaces first
            state_nxt = sts.row_ok ? tcg_pkg::ST_WRITE : tcg_pkg::ST_SWEEP;
          end
          tcg_pkg::KIND_READ: begin
            cmd.rd_issue = 1'b1;
            state_nxt    = tcg_pkg::ST_DONE;
          end
          default: begin
            cmd.apply = 1'b1;
            state_nxt = tcg_pkg::ST_DONE;
          end
        endcase
      end
      tcg_pkg::ST_SWEEP: begin
        cmd.sweep_wr = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = tcg_pkg::ST_WRITE;
        end
      end
      tcg_pkg::ST_WRITE: begin
        cmd.put_wr = 1'b1;
        state_nxt  = tcg_pkg::ST_DONE;
      end
      tcg_pkg::ST_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = tcg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tcg_pkg::ST_IDLE;
      end
    endcase
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tcg_pkg::ST_DONE && sts.out_free) |=> state_r == tcg_pkg::ST_IDLE)
    else $error("result transaction not followed by idle");

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cap |=> state_r == tcg_pkg::ST_EXEC)
    else $error("captured item not executed");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tcg_pkg::ST_SWEEP && !sts.sweep_last) |=> state_r == tcg_pkg::ST_SWEEP)
    else $error("row sweep left early");

endmodule

[sv/tcg_datapath.sv]
// cursor, scroll base, row flags, character memory and result register
`timescale 1ns / 1ps
module tcg_datapath #(
  parameter int COLUMNS = 40,
  parameter int ROWS    = 20
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  tcg_pkg::cmd_t              cmd,
  output tcg_pkg::sts_t              sts,
  input  logic [tcg_pkg::MODE_W-1:0] in_mode,
  input  logic [tcg_pkg::CHAR_W-1:0] in_char_code,
  input  logic [tcg_pkg::RROW_W-1:0] in_read_row,
  input  logic [tcg_pkg::RCOL_W-1:0] in_read_col,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [tcg_pkg::OCOL_W-1:0] out_cursor_col,
  output logic [tcg_pkg::OROW_W-1:0] out_cursor_row,
  output logic [tcg_pkg::CHAR_W-1:0] out_cell_char,
  output logic                       out_scrolled
);

  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int DEPTH = ROWS * COLUMNS;
  localparam int AW    = $clog2(DEPTH);
  localparam int OCW   = tcg_pkg::OCOL_W;
  localparam int ORW   = tcg_pkg::OROW_W;

  logic [tcg_pkg::MODE_W-1:0] mode_r;
  logic [tcg_pkg::CHAR_W-1:0] ch_r;
  logic [tcg_pkg::RROW_W-1:0] rr_r;
  logic [tcg_pkg::RCOL_W-1:0] rc_r;

  logic [CW-1:0]   cur_x_r, cur_x_nxt;
  logic [RW-1:0]   cur_y_r, cur_y_nxt;
  logic [RW-1:0]   base_r, base_nxt;
  logic [ROWS-1:0] row_ok_r, row_ok_nxt;
  logic            scr_r, scr_nxt;
  logic [CW-1:0]   swp_r;

  logic [tcg_pkg::CHAR_W-1:0] mem [0:DEPTH-1];
  logic [tcg_pkg::CHAR_W-1:0] rd_q_r;
  logic                       rd_inr_r;
  logic                       rd_ok_r;

  logic                       out_valid_r;
  logic [OCW-1:0]             out_col_r;
  logic [ORW-1:0]             out_row_r;
  logic [tcg_pkg::CHAR_W-1:0] out_cell_r;
  logic                       out_scr_r;

  logic [RW:0]                sum_cur, sum_rd;
  logic [RW-1:0]              prow_cur, prow_rd;
  logic                       rd_inr;
  logic [AW-1:0]              wr_addr, rd_addr;
  logic [tcg_pkg::CHAR_W-1:0] wr_data;
  logic                       wr_en;
  logic                       is_char;

  // logical row to physical row; base and cursor row are below ROWS, the read row may not be
  always_comb begin
    sum_cur  = {1'b0, base_r} + {1'b0, cur_y_r};
    sum_rd   = {1'b0, base_r} + (RW+1)'(rr_r);
    prow_cur = (int'(sum_cur) >= ROWS) ? RW'(int'(sum_cur) - ROWS) : RW'(sum_cur);
    prow_rd  = (int'(sum_rd) >= ROWS) ? RW'(int'(sum_rd) - ROWS) : RW'(sum_rd);
    rd_inr   = (int'(rr_r) < ROWS) && (int'(rc_r) < COLUMNS);
  end

  always_comb begin
    is_char = (mode_r == tcg_pkg::MODE_PUT) && (ch_r != tcg_pkg::CH_CR) &&
              (ch_r != tcg_pkg::CH_LF) && (ch_r != tcg_pkg::CH_BS);
    if (is_char) begin
      sts.kind = tcg_pkg::KIND_CHAR;
    end else if (mode_r == tcg_pkg::MODE_READ) begin
      sts.kind = tcg_pkg::KIND_READ;
    end else begin
      sts.kind = tcg_pkg::KIND_OTHER;
    end
    sts.row_ok     = row_ok_r[prow_cur];
    sts.sweep_last = (swp_r == CW'(COLUMNS - 1));
    sts.out_free   = !out_valid_r || out_ready;
  end

  always_comb begin
    wr_en   = cmd.sweep_wr || cmd.put_wr;
    wr_data = cmd.sweep_wr ? tcg_pkg::CH_SPACE : ch_r;
    wr_addr = AW'(prow_cur) * AW'(COLUMNS) + AW'(cmd.sweep_wr ? swp_r : cur_x_r);
    rd_addr = rd_inr ? (AW'(prow_rd) * AW'(COLUMNS) + AW'(rc_r)) : '0;
  end

  always_comb begin
    cur_x_nxt  = cur_x_r;
    cur_y_nxt  = cur_y_r;
    base_nxt   = base_r;
    row_ok_nxt = row_ok_r;
    scr_nxt    = scr_r;
    if (cmd.cap) begin
      scr_nxt = 1'b0;
    end
    if (cmd.apply) begin
      case (mode_r)
        tcg_pkg::MODE_PUT: begin
          case (ch_r)
            tcg_pkg::CH_CR: begin
              cur_x_nxt = '0;
            end
            tcg_pkg::CH_LF: begin
              if (cur_y_r == RW'(ROWS - 1)) begin
                // old top row becomes the blank bottom row
                row_ok_nxt[base_r] = 1'b0;
                base_nxt = (base_r == RW'(ROWS - 1)) ? '0 : base_r + 1'b1;
                scr_nxt  = 1'b1;
              end else begin
                cur_y_nxt = cur_y_r + 1'b1;
              end
            end
            tcg_pkg::CH_BS: begin
              if (cur_x_r != '0) begin
                cur_x_nxt = cur_x_r - 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
        tcg_pkg::MODE_CLEAR: begin
          cur_x_nxt  = '0;
          cur_y_nxt  = '0;
          base_nxt   = '0;
          row_ok_nxt = '0;
        end
        default: begin
        end
      endcase
    end
    if (cmd.put_wr && cur_x_r != CW'(COLUMNS - 1)) begin
      cur_x_nxt = cur_x_r + 1'b1;
    end
    if (cmd.sweep_wr && sts.sweep_last) begin
      row_ok_nxt[prow_cur] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      base_r      <= '0;
      row_ok_r    <= '0;
      scr_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_x_r  <= cur_x_nxt;
      cur_y_r  <= cur_y_nxt;
      base_r   <= base_nxt;
      row_ok_r <= row_ok_nxt;
      scr_r    <= scr_nxt;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      mode_r <= in_mode;
      ch_r   <= in_char_code;
      rr_r   <= in_read_row;
      rc_r   <= in_read_col;
      swp_r  <= '0;
    end else if (cmd.sweep_wr) begin
      swp_r <= swp_r + 1'b1;
    end
    if (cmd.rd_issue) begin
      rd_inr_r <= rd_inr;
      rd_ok_r  <= rd_inr && row_ok_r[prow_rd];
    end
    if (cmd.load_out) begin
      out_col_r <= OCW'(cur_x_r);
      out_row_r <= ORW'(cur_y_r);
      out_scr_r <= scr_r;
      if (mode_r == tcg_pkg::MODE_READ && rd_inr_r) begin
        out_cell_r <= rd_ok_r ? rd_q_r : tcg_pkg::CH_SPACE;
      end else begin
        out_cell_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_issue) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cursor_col = out_col_r;
  assign out_cursor_row = out_row_r;
  assign out_cell_char  = out_cell_r;
  assign out_scrolled   = out_scr_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    int'(cur_y_r) < ROWS && int'(cur_x_r) < COLUMNS && int'(base_r) < ROWS)
    else $error("cursor or scroll base outside the grid");

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.put_wr |-> row_ok_r[prow_cur])
    else $error("character written into a row not yet blanked");

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result register overwritten before its transaction");

endmodule

[sv/text_console_grid_top.sv]
// top level of the text console grid
// sequence: an item is captured in IDLE and handled in EXEC; a stored character also passes through
//   WRITE, and first through SWEEP when its row was blanked by scroll or clear; DONE loads the result
// input: a new item is taken only in IDLE, once the result of the last one is loaded; a held result
//   stalls the input
// reset: synchronous, active low; cursor, scroll base and row flags clear at once, every row
//   then reads as spaces, so no clearing pass is run and items are taken on the next cycle
`timescale 1ns / 1ps
module text_console_grid_top #(
  parameter int COLUMNS = 40,
  parameter int ROWS    = 20
) (
  input  logic       clk,
  input  logic       rst_n,
  tcg_in_if.sink     in_ch,
  tcg_out_if.source  out_ch
);

  tcg_pkg::cmd_t cmd;
  tcg_pkg::sts_t sts;

  tcg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tcg_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_mode        (in_ch.mode),
    .in_char_code   (in_ch.char_code),
    .in_read_row    (in_ch.read_row),
    .in_read_col    (in_ch.read_col),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_cursor_col (out_ch.cursor_col),
    .out_cursor_row (out_ch.cursor_row),
    .out_cell_char  (out_ch.cell_char),
    .out_scrolled   (out_ch.scrolled)
  );

endmodule

[sim/tb_top.sv]
// testbench for the text console grid: directed and random console traffic checked against a grid model
`timescale 1ns / 1ps
module tb_top;

  localparam int COLUMNS = 40;
  localparam int ROWS    = 20;
  localparam int N_ITEMS = 2000;
  localparam int HOLD_CYCLES = 300;

  typedef logic [tcg_pkg::CHAR_W-1:0] char_t;
  typedef logic [tcg_pkg::RROW_W-1:0] rrow_t;
  typedef logic [tcg_pkg::RCOL_W-1:0] rcol_t;

  typedef struct packed {
    logic [tcg_pkg::OCOL_W-1:0] col;
    logic [tcg_pkg::OROW_W-1:0] row;
    logic [tcg_pkg::CHAR_W-1:0] cell_char;
    logic                       scrolled;
  } console_result_t;

  // grid model with a rotating top row, plus the queue of results still to arrive
  class console_scoreboard;
    logic [tcg_pkg::CHAR_W-1:0] cells [ROWS*COLUMNS];
    int unsigned       cur_col;
    int unsigned       cur_row;
    int unsigned       base_row;
    console_result_t   pending [$];
    int                errors;
    int                checked;
    int                scrolls;
    int                clamps;

    function new();
      clear_screen();
    endfunction

    function void clear_screen();
      foreach (cells[i]) cells[i] = tcg_pkg::CH_SPACE;
      cur_col  = 0;
      cur_row  = 0;
      base_row = 0;
    endfunction

    function int unsigned cell_index(int unsigned r, int unsigned c);
      return ((base_row + r) % ROWS) * COLUMNS + c;
    endfunction

    function void note_input(tcg_pkg::mode_t m, char_t ch, rrow_t rr, rcol_t rc);
      console_result_t want;
      want = '0;
      case (m)
        tcg_pkg::MODE_PUT: begin
          if (ch == tcg_pkg::CH_CR) begin
            cur_col = 0;
          end else if (ch == tcg_pkg::CH_LF) begin
            if (cur_row >= ROWS - 1) begin
              // old top row is blanked and becomes the bottom row
              for (int i = 0; i < COLUMNS; i++) cells[base_row*COLUMNS + i] = tcg_pkg::CH_SPACE;
              base_row = (base_row + 1) % ROWS;
              want.scrolled = 1'b1;
              scrolls++;
            end else begin
              cur_row++;
            end
          end else if (ch == tcg_pkg::CH_BS) begin
            if (cur_col != 0) cur_col--;
          end else begin
            cells[cell_index(cur_row, cur_col)] = ch;
            if (cur_col + 1 < COLUMNS) cur_col++;
            else clamps++;
          end
        end
        tcg_pkg::MODE_CLEAR: clear_screen();
        tcg_pkg::MODE_READ: begin
          if (rr < ROWS && rc < COLUMNS) want.cell_char = cells[cell_index(rr, rc)];
        end
        default: ;
      endcase
      want.col = cur_col[tcg_pkg::OCOL_W-1:0];
      want.row = cur_row[tcg_pkg::OROW_W-1:0];
      pending.push_back(want);
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(console_result_t got);
      console_result_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result col %0d row %0d char %02h scrolled %0d",
                         got.col, got.row, got.cell_char, got.scrolled));
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.col !== want.col)
        report($sformatf("result %0d cursor_col %0d, wanted %0d", checked, got.col, want.col));
      if (got.row !== want.row)
        report($sformatf("result %0d cursor_row %0d, wanted %0d", checked, got.row, want.row));
      if (got.cell_char !== want.cell_char)
        report($sformatf("result %0d cell_char %02h, wanted %02h", checked, got.cell_char,
                         want.cell_char));
      if (got.scrolled !== want.scrolled)
        report($sformatf("result %0d scrolled %0d, wanted %0d", checked, got.scrolled,
                         want.scrolled));
    endtask
  endclass

  logic clk;
  logic rst_n;

  tcg_in_if  in_ch ();
  tcg_out_if out_ch ();

  text_console_grid_top #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  console_scoreboard sb;
  int  n_sent;
  int  n_by_mode [4];
  bit  long_hold;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("FAILURE");
    $finish;
  end

  task automatic send_item(tcg_pkg::mode_t m, char_t ch, rrow_t rr, rcol_t rc);
    int gap;
    // every fifth block of items goes without gaps
    gap = (((n_sent / 128) % 5) == 2) ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.mode      <= m;
    in_ch.char_code <= ch;
    in_ch.read_row  <= rr;
    in_ch.read_col  <= rc;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    sb.note_input(m, ch, rr, rc);
    n_sent++;
    n_by_mode[m]++;
  endtask

  task automatic put_char(char_t ch);
    send_item(tcg_pkg::MODE_PUT, ch, rrow_t'($urandom_range(0, 31)),
              rcol_t'($urandom_range(0, 63)));
  endtask

  task automatic read_cell(rrow_t rr, rcol_t rc);
    send_item(tcg_pkg::MODE_READ, char_t'($urandom_range(0, 255)), rr, rc);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
  endtask

  // result side
  initial begin
    int gap;
    int rx_count;
    console_result_t got;
    rx_count = 0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (long_hold) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end
      gap = (((rx_count / 150) % 4) == 1) ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      got.col       = out_ch.cursor_col;
      got.row       = out_ch.cursor_row;
      got.cell_char = out_ch.cell_char;
      got.scrolled  = out_ch.scrolled;
      sb.check_result(got);
      rx_count++;
    end
  end

  // stimulus
  initial begin
    int  len;
    int  pick;
    bit  paused;
    sb        = new();
    n_sent    = 0;
    long_hold = 1'b0;
    paused    = 1'b0;
    foreach (n_by_mode[i]) n_by_mode[i] = 0;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.mode      <= tcg_pkg::MODE_PUT;
    in_ch.char_code <= '0;
    in_ch.read_row  <= '0;
    in_ch.read_col  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, every mode, out-of-grid reads, backspace at column 0
    read_cell(0, 0);
    put_char(tcg_pkg::CH_BS);
    put_char(8'h00);
    put_char(8'hff);
    put_char("A");
    put_char(tcg_pkg::CH_BS);
    put_char("Z");
    read_cell(0, 0);
    read_cell(0, 1);
    read_cell(0, 2);
    read_cell(31, 63);
    read_cell(rrow_t'(ROWS), 0);
    read_cell(0, rcol_t'(COLUMNS));
    read_cell(rrow_t'(ROWS - 1), rcol_t'(COLUMNS - 1));
    send_item(tcg_pkg::MODE_NONE, 8'hff, 5'h1f, 6'h3f);
    send_item(tcg_pkg::MODE_NONE, 8'h00, 5'h00, 6'h00);
    put_char(tcg_pkg::CH_CR);
    put_char(tcg_pkg::CH_LF);
    put_char("q");
    read_cell(1, 0);
    send_item(tcg_pkg::MODE_CLEAR, 8'hff, 5'h1f, 6'h3f);
    read_cell(1, 0);
    read_cell(0, 0);

    // receiver goes quiet for a while so the block backs up
    long_hold = 1'b1;

    while (n_sent < N_ITEMS) begin
      if (!paused && n_sent >= N_ITEMS / 2) begin
        paused = 1'b1;
        wait_drained();
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        // one line of text, some long enough to pin the cursor at the last column
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(COLUMNS - 2, COLUMNS + 10)
                                          : $urandom_range(0, 30);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 7) == 0)
            read_cell(rrow_t'($urandom_range(0, ROWS - 1)),
                      rcol_t'($urandom_range(0, COLUMNS - 1)));
          if ($urandom_range(0, 19) == 0) put_char(tcg_pkg::CH_BS);
          put_char(char_t'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                                       : $urandom_range(32, 126)));
        end
        case ($urandom_range(0, 3))
          0, 1: begin
            put_char(tcg_pkg::CH_CR);
            put_char(tcg_pkg::CH_LF);
          end
          2: begin
            put_char(tcg_pkg::CH_LF);
            put_char(tcg_pkg::CH_CR);
          end
          default: put_char(tcg_pkg::CH_LF);
        endcase
      end else if (pick < 80) begin
        repeat (5) begin
          if ($urandom_range(0, 3) == 0)
            read_cell(rrow_t'($urandom_range(0, 31)), rcol_t'($urandom_range(0, 63)));
          else
            read_cell(rrow_t'($urandom_range(0, ROWS - 1)),
                      rcol_t'($urandom_range(0, COLUMNS - 1)));
        end
      end else if (pick < 88) begin
        repeat ($urandom_range(1, 25)) put_char(tcg_pkg::CH_LF);
      end else if (pick < 95) begin
        send_item(tcg_pkg::MODE_NONE, char_t'($urandom_range(0, 255)),
                  rrow_t'($urandom_range(0, 31)), rcol_t'($urandom_range(0, 63)));
        put_char(tcg_pkg::CH_BS);
      end else if (pick < 97) begin
        send_item(tcg_pkg::MODE_CLEAR, char_t'($urandom_range(0, 255)),
                  rrow_t'($urandom_range(0, 31)), rcol_t'($urandom_range(0, 63)));
      end else begin
        wait_drained();
      end
    end

    wait_drained();
    repeat (COLUMNS + 20) @(posedge clk);

    $display("covered %0d items: %0d puts, %0d clears, %0d reads, %0d of unused mode",
             n_sent, n_by_mode[tcg_pkg::MODE_PUT], n_by_mode[tcg_pkg::MODE_CLEAR],
             n_by_mode[tcg_pkg::MODE_READ], n_by_mode[tcg_pkg::MODE_NONE]);
    $display("%0d results checked, %0d scrolls, %0d writes clamped at the last column",
             sb.checked, sb.scrolls, sb.clamps);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
